>>> rtl/iira_pkg.sv
// package: action codes, channel payloads and cell control for the indexed insert/remove array
`default_nettype none
package iira_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  item_value;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count_after;
        logic               rejected;
    } t_rsp;

    typedef struct packed {
        logic push;
        logic ins;
        logic rem;
    } t_cell_op;

endpackage
`default_nettype wire

>>> rtl/iira_if.sv
// interface: valid/ready channel carrying one payload
`default_nettype none
interface iira_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/iira_cell.sv
// module: one storage cell of the array, loads a new value or a neighbor's entry
`default_nettype none
module iira_cell #(
    parameter int DATA_WIDTH = iira_pkg::DATA_WIDTH_DEF,
    parameter int CW         = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  iira_pkg::t_cell_op    i_op,
    input  logic [CW-1:0]         i_pos,
    input  logic [CW-1:0]         i_cnt,
    input  logic [DATA_WIDTH-1:0] i_val,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);
    import iira_pkg::*;

    localparam logic [CW-1:0] K  = CW'(INDEX);
    localparam logic [CW:0]   K1 = (CW + 1)'(INDEX + 1);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  load_new;
    logic                  load_left;
    logic                  load_right;

    assign load_new   = (i_op.push && i_cnt == K) || (i_op.ins && i_pos == K);
    assign load_left  = i_op.ins && K > i_pos && K <= i_cnt;
    assign load_right = i_op.rem && K >= i_pos && {1'b0, i_cnt} > K1;

    always_comb begin
        priority if (load_new) begin
            n_data = i_val;
        end else if (load_left) begin
            n_data = i_left;
        end else if (load_right) begin
            n_data = i_right;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> rtl/indexed_insert_remove_array.sv
// top level: ordered array of cells with push, pop, insert, remove, read and clear
//
//  channel   dir  modport  payload
//  i_req     in   sink     action, position, item_value
//  o_rsp     out  source   read_value, count_after, rejected
//
//  one item per cycle while i_req.ready is high: every cell shifts or loads in parallel at the transfer edge
//  the result sits in an output register the cycle after the transfer
//  i_req.ready drops only while a result is held and o_rsp.ready is low
//  reset clears the entry count and the output valid; cell contents are not reset
`default_nettype none
module indexed_insert_remove_array #(
    parameter int CAPACITY   = iira_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = iira_pkg::DATA_WIDTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    iira_if.sink   i_req,
    iira_if.source o_rsp
);
    import iira_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         n_cnt;
    logic                  r_out_valid;
    t_rsp                  r_rsp;
    t_rsp                  rsp;
    t_cell_op              op;
    t_cell_op              cell_op;
    logic                  xfer_in;
    logic                  rej;
    logic                  full;
    logic                  empty;
    logic [EW-1:0]         pos_w;
    logic [EW-1:0]         cnt_w;
    logic                  pos_in;
    logic [DATA_WIDTH-1:0] rd_sel;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] new_val;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign xfer_in     = i_req.valid && i_req.ready;

    assign full    = r_cnt == CW'(CAPACITY);
    assign empty   = r_cnt == '0;
    assign pos_w   = EW'(i_req.data.position);
    assign cnt_w   = EW'(r_cnt);
    assign pos_in  = pos_w < cnt_w;
    assign new_val = DATA_WIDTH'(i_req.data.item_value);

    always_comb begin
        rd_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (pos_w == EW'(k)) begin
                rd_sel = rd_sel | cell_data[k];
            end
        end
    end

    always_comb begin
        op      = '0;
        rej     = 1'b0;
        n_cnt   = r_cnt;
        rd_data = '0;
        unique case (i_req.data.action)
            ACT_PUSH: begin
                if (full) begin
                    rej = 1'b1;
                end else begin
                    op.push = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            ACT_POP: begin
                if (empty) begin
                    rej = 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ACT_INSERT: begin
                if (full || pos_w > cnt_w) begin
                    rej = 1'b1;
                end else begin
                    op.ins = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (!pos_in) begin
                    rej = 1'b1;
                end else begin
                    op.rem = 1'b1;
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            ACT_READ: begin
                if (!pos_in) begin
                    rej = 1'b1;
                end else begin
                    rd_data = rd_sel;
                end
            end
            ACT_CLEAR: begin
                if (empty) begin
                    rej = 1'b1;
                end else begin
                    n_cnt = '0;
                end
            end
            default: begin
                rej = 1'b1;
            end
        endcase
    end

    assign cell_op = xfer_in ? op : '0;

    assign rsp.read_value  = VALUE_W'(rd_data);
    assign rsp.count_after = COUNT_W'(n_cnt);
    assign rsp.rejected    = rej;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_l
            assign left_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_mid_r
            assign right_data = cell_data[g+1];
        end

        iira_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_pos   (CW'(i_req.data.position)),
            .i_cnt   (r_cnt),
            .i_val   (new_val),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (xfer_in) begin
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer_in) begin
            r_rsp <= rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_rej_keeps_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer_in && rej |=> r_cnt == $past(r_cnt))
        else $error("refused action changed the entry count");

    a_read_keeps_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer_in && i_req.data.action == ACT_READ |=> r_cnt == $past(r_cnt))
        else $error("read changed the entry count");

    a_out_matches_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer_in |=> o_rsp.data.count_after == COUNT_W'(r_cnt))
        else $error("reported count differs from the stored count");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid)
        else $error("pending result dropped before transfer");

endmodule
`default_nettype wire
